### src/pcent_pkg.sv
// ----------------------------------------------------------------------------
// pcent_pkg
// shared types and constants for the polygon centroid block
// ----------------------------------------------------------------------------
package pcent_pkg;

  // coordinate word width, fixed by the vertex and centroid formats
  localparam int DATA_W           = 16;
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int COORD_BITS_DEF   = 16;

  typedef logic signed [DATA_W-1:0] coord_t;

  typedef struct packed {
    coord_t vert_x;
    coord_t vert_y;
    coord_t vert_z;
    logic   last_vertex;
  } vert_t;

  typedef struct packed {
    coord_t centroid_x;
    coord_t centroid_y;
    coord_t centroid_z;
    logic   degenerate;
    logic   overflowed;
  } cent_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_CROSS0,
    ST_CROSS1,
    ST_CROSS2,
    ST_MOMX,
    ST_MOMY,
    ST_MOMY_ACC,
    ST_DIV_D3,
    ST_DIV_LD,
    ST_DIV_RUN,
    ST_DIV_END,
    ST_OUT
  } state_e;

endpackage

### src/pcent_vert_if.sv
// ----------------------------------------------------------------------------
// pcent_vert_if
// valid/ready channel carrying one polygon vertex word
// ----------------------------------------------------------------------------
interface pcent_vert_if;
  import pcent_pkg::*;

  logic  valid;
  logic  ready;
  vert_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/pcent_res_if.sv
// ----------------------------------------------------------------------------
// pcent_res_if
// valid/ready channel carrying one centroid result word
// ----------------------------------------------------------------------------
interface pcent_res_if;
  import pcent_pkg::*;

  logic  valid;
  logic  ready;
  cent_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/polygon_centroid.sv
// ----------------------------------------------------------------------------
// polygon_centroid
// shoelace centroid of a closed polygon, vertices streamed one word at a time
// ----------------------------------------------------------------------------
//
//  channel   dir  word                                       taken when
//  --------  ---  -----------------------------------------  -----------------
//  vert_i    in   vert_x, vert_y, vert_z, last_vertex        valid && ready
//  res_o     out  centroid_x/y/z, degenerate, overflowed     valid && ready
//
//  a vertex that adds an edge is accepted, then goes through the steps on
//  the one shared 17x33 multiplier (two cross products, two moments)
//  the first vertex, or one past MAX_VERTICES, adds no edge of its own
//  the last vertex adds the closing edge, then the x and y quotients are formed
//  in turn in the shared radix-2 restoring divider
//  the result sits in an output register; a new polygon is taken while it waits
//  reset clears the control state and accumulators at once, no clearing pass
//
module polygon_centroid #(
  parameter int MAX_VERTICES = pcent_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = pcent_pkg::COORD_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pcent_vert_if.sink   vert_i,
  pcent_res_if.source  res_o
);
  import pcent_pkg::*;

  // accumulator widths
  localparam int CNTW = $clog2(MAX_VERTICES + 1);   // vertex count
  localparam int SW   = DATA_W + 1;                 // coordinate sum
  localparam int PW   = 2 * DATA_W + 1;             // cross product
  localparam int PRW  = SW + PW;                    // multiplier product
  localparam int AW   = PW + CNTW;                  // twice area
  localparam int MW   = PRW + CNTW;                 // moments
  localparam int D3W  = AW + 2;                     // three times twice area
  localparam int DW   = AW + 1;                     // divisor magnitude
  localparam int CTW  = $clog2(MW);                 // divider step count

  localparam logic [CNTW-1:0]   MAXC   = CNTW'(MAX_VERTICES);
  localparam logic [CTW-1:0]    LAST_STEP = CTW'(MW - 1);
  localparam logic [MW-1:0]     QLIM   = {{(MW-1){1'b0}}, 1'b1} << (COORD_BITS - 1);
  localparam logic [DATA_W-1:0] C_LIM  = QLIM[DATA_W-1:0];
  localparam logic [DATA_W-1:0] C_HI   = C_LIM - DATA_W'(1);
  localparam logic [DATA_W-1:0] C_LO   = ~C_HI;

  // control state
  state_e              state_q, state_d;
  logic [CNTW-1:0]     count_q, count_d;
  logic                dropped_q, dropped_d;
  logic                last_q, last_d;       // current vertex ends the polygon
  logic                closing_q, closing_d; // edge in flight is the closing edge
  logic                out_valid_q, out_valid_d;

  // vertex registers
  coord_t              first_x_q, first_x_d, first_y_q, first_y_d, first_z_q, first_z_d;
  coord_t              prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  coord_t              ex0_q, ex0_d, ey0_q, ey0_d, ex1_q, ex1_d, ey1_q, ey1_d;

  // accumulators
  logic signed [PRW-1:0] p_q, p_d;
  logic signed [PW-1:0]  a_q, a_d;
  logic signed [AW-1:0]  area_q, area_d;
  logic signed [MW-1:0]  mx_q, mx_d, my_q, my_d;

  // divider
  logic signed [D3W-1:0] d3_q, d3_d;
  logic [DW-1:0]         dmag_q, dmag_d;
  logic [DW-1:0]         rem_q, rem_d;
  logic [MW-1:0]         quo_q, quo_d;
  logic                  qneg_q, qneg_d;
  logic [CTW-1:0]        dcnt_q, dcnt_d;
  logic                  sel_y_q, sel_y_d;

  // result
  coord_t                cx_q, cx_d, cy_q, cy_d;
  logic                  sat_q, sat_d;
  logic                  degen_q, degen_d;
  cent_t                 out_q, out_d;

  // shared multiplier
  logic signed [SW-1:0]  op_a;
  logic signed [PW-1:0]  op_b;
  logic signed [SW-1:0]  sum_x, sum_y;

  // helper values
  logic                  vert_acc;
  logic                  out_free;
  logic signed [D3W-1:0] area_ext, d3_abs;
  logic signed [MW-1:0]  num, num_abs;
  logic [DW:0]           rem_sh;
  logic [DW+1:0]         diff;
  logic                  qbit;
  coord_t                qval, qres;
  logic                  qsat;

  assign vert_i.ready = (state_q == ST_IDLE);
  assign vert_acc     = vert_i.valid && vert_i.ready;
  assign out_free     = !out_valid_q || res_o.ready;
  assign res_o.valid  = out_valid_q;
  assign res_o.data   = out_q;

  // edge sums for the moments
  assign sum_x = {ex0_q[DATA_W-1], ex0_q} + {ex1_q[DATA_W-1], ex1_q};
  assign sum_y = {ey0_q[DATA_W-1], ey0_q} + {ey1_q[DATA_W-1], ey1_q};

  // operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_q)
      ST_CROSS0: begin
        op_a = {ex0_q[DATA_W-1], ex0_q};
        op_b = {{(PW-DATA_W){ey1_q[DATA_W-1]}}, ey1_q};
      end
      ST_CROSS1: begin
        op_a = {ex1_q[DATA_W-1], ex1_q};
        op_b = {{(PW-DATA_W){ey0_q[DATA_W-1]}}, ey0_q};
      end
      ST_MOMX: begin
        op_a = sum_x;
        op_b = a_q;
      end
      ST_MOMY: begin
        op_a = sum_y;
        op_b = a_q;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign p_d = op_a * op_b;

  // divider step and quotient clamp
  assign area_ext = {{2{area_q[AW-1]}}, area_q};
  assign d3_abs   = d3_q[D3W-1] ? -d3_q : d3_q;
  assign num      = sel_y_q ? my_q : mx_q;
  assign num_abs  = num[MW-1] ? -num : num;
  assign rem_sh   = {rem_q, quo_q[MW-1]};
  assign diff     = {1'b0, rem_sh} - {2'b00, dmag_q};
  assign qbit     = !diff[DW+1];
  assign qval     = quo_q[DATA_W-1:0];

  always_comb begin
    qsat = 1'b0;
    qres = qval;
    if (!qneg_q) begin
      if (quo_q >= QLIM) begin
        qsat = 1'b1;
        qres = C_HI;
      end
    end else begin
      if (quo_q > QLIM) begin
        qsat = 1'b1;
        qres = C_LO;
      end else begin
        qres = -qval;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (vert_acc) begin
          if (count_q < MAXC && count_q != '0) begin
            state_d = ST_CROSS0;
          end else if (vert_i.data.last_vertex) begin
            state_d = ST_CLOSE;
          end
        end
      end
      ST_CLOSE:    state_d = ST_CROSS0;
      ST_CROSS0:   state_d = ST_CROSS1;
      ST_CROSS1:   state_d = ST_CROSS2;
      ST_CROSS2:   state_d = ST_MOMX;
      ST_MOMX:     state_d = ST_MOMY;
      ST_MOMY:     state_d = ST_MOMY_ACC;
      ST_MOMY_ACC: begin
        if (closing_q) begin
          state_d = ST_DIV_D3;
        end else if (last_q) begin
          state_d = ST_CLOSE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV_D3: begin
        // zero area skips the divider
        state_d = (area_q == '0) ? ST_OUT : ST_DIV_LD;
      end
      ST_DIV_LD:   state_d = ST_DIV_RUN;
      ST_DIV_RUN: begin
        if (dcnt_q == LAST_STEP) begin
          state_d = ST_DIV_END;
        end
      end
      ST_DIV_END:  state_d = sel_y_q ? ST_OUT : ST_DIV_LD;
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_d     = count_q;
    dropped_d   = dropped_q;
    last_d      = last_q;
    closing_d   = closing_q;
    out_valid_d = out_valid_q && !res_o.ready;
    first_x_d   = first_x_q;
    first_y_d   = first_y_q;
    first_z_d   = first_z_q;
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    ex0_d       = ex0_q;
    ey0_d       = ey0_q;
    ex1_d       = ex1_q;
    ey1_d       = ey1_q;
    a_d         = a_q;
    area_d      = area_q;
    mx_d        = mx_q;
    my_d        = my_q;
    d3_d        = d3_q;
    dmag_d      = dmag_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    qneg_d      = qneg_q;
    dcnt_d      = dcnt_q;
    sel_y_d     = sel_y_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    sat_d       = sat_q;
    degen_d     = degen_q;
    out_d       = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (vert_acc) begin
          last_d = vert_i.data.last_vertex;
          if (count_q >= MAXC) begin
            dropped_d = 1'b1;
          end else begin
            if (count_q == '0) begin
              first_x_d = vert_i.data.vert_x;
              first_y_d = vert_i.data.vert_y;
              first_z_d = vert_i.data.vert_z;
            end else begin
              ex0_d = prev_x_q;
              ey0_d = prev_y_q;
              ex1_d = vert_i.data.vert_x;
              ey1_d = vert_i.data.vert_y;
            end
            prev_x_d = vert_i.data.vert_x;
            prev_y_d = vert_i.data.vert_y;
            count_d  = count_q + CNTW'(1);
          end
        end
      end
      ST_CLOSE: begin
        // ring closes from the last held vertex back to the first
        ex0_d     = prev_x_q;
        ey0_d     = prev_y_q;
        ex1_d     = first_x_q;
        ey1_d     = first_y_q;
        closing_d = 1'b1;
      end
      ST_CROSS0: begin
      end
      ST_CROSS1: a_d = p_q[PW-1:0];
      ST_CROSS2: a_d = a_q - p_q[PW-1:0];
      ST_MOMX:   area_d = area_q + {{(AW-PW){a_q[PW-1]}}, a_q};
      ST_MOMY:   mx_d = mx_q + {{(MW-PRW){p_q[PRW-1]}}, p_q};
      ST_MOMY_ACC: begin
        my_d = my_q + {{(MW-PRW){p_q[PRW-1]}}, p_q};
      end
      ST_DIV_D3: begin
        closing_d = 1'b0;
        degen_d   = (area_q == '0);
        sat_d     = 1'b0;
        sel_y_d   = 1'b0;
        cx_d      = '0;
        cy_d      = '0;
        d3_d      = area_ext + {area_ext[D3W-2:0], 1'b0};
      end
      ST_DIV_LD: begin
        dmag_d = d3_abs[DW-1:0];
        quo_d  = num_abs;
        rem_d  = '0;
        dcnt_d = '0;
        qneg_d = num[MW-1] ^ d3_q[D3W-1];
      end
      ST_DIV_RUN: begin
        rem_d  = qbit ? diff[DW-1:0] : rem_sh[DW-1:0];
        quo_d  = {quo_q[MW-2:0], qbit};
        dcnt_d = dcnt_q + CTW'(1);
      end
      ST_DIV_END: begin
        if (sel_y_q) begin
          cy_d = qres;
        end else begin
          cx_d = qres;
        end
        sat_d   = sat_q | qsat;
        sel_y_d = 1'b1;
      end
      ST_OUT: begin
        if (out_free) begin
          out_d.centroid_x = cx_q;
          out_d.centroid_y = cy_q;
          out_d.centroid_z = first_z_q;
          out_d.degenerate = degen_q;
          out_d.overflowed = sat_q | dropped_q;
          out_valid_d      = 1'b1;
          // polygon state back to reset for the next ring
          count_d   = '0;
          dropped_d = 1'b0;
          last_d    = 1'b0;
          area_d    = '0;
          mx_d      = '0;
          my_d      = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // control and accumulator registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      last_q      <= 1'b0;
      closing_q   <= 1'b0;
      out_valid_q <= 1'b0;
      area_q      <= '0;
      mx_q        <= '0;
      my_q        <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      last_q      <= last_d;
      closing_q   <= closing_d;
      out_valid_q <= out_valid_d;
      area_q      <= area_d;
      mx_q        <= mx_d;
      my_q        <= my_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    first_x_q <= first_x_d;
    first_y_q <= first_y_d;
    first_z_q <= first_z_d;
    prev_x_q  <= prev_x_d;
    prev_y_q  <= prev_y_d;
    ex0_q     <= ex0_d;
    ey0_q     <= ey0_d;
    ex1_q     <= ex1_d;
    ey1_q     <= ey1_d;
    p_q       <= p_d;
    a_q       <= a_d;
    d3_q      <= d3_d;
    dmag_q    <= dmag_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    qneg_q    <= qneg_d;
    dcnt_q    <= dcnt_d;
    sel_y_q   <= sel_y_d;
    cx_q      <= cx_d;
    cy_q      <= cy_d;
    sat_q     <= sat_d;
    degen_q   <= degen_d;
    out_q     <= out_d;
  end

endmodule

### src/pcent_chk.sv
// ----------------------------------------------------------------------------
// pcent_chk
// port-level checks on the polygon centroid block, bound to the top level
// ----------------------------------------------------------------------------
module pcent_chk (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_last,
  input logic             res_valid,
  input logic             res_ready,
  input logic             res_degenerate,
  input pcent_pkg::coord_t res_cx,
  input pcent_pkg::coord_t res_cy
);
  import pcent_pkg::*;

  // a result word holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid)
    else $error("result word dropped before it was taken");

  // zero area gives a zero centroid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_degenerate |-> res_cx == '0 && res_cy == '0)
    else $error("degenerate result with nonzero centroid");

  // the last vertex leads on to the closing edge, so the input stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input taken right after the last vertex");

  // a new result word appears only as the sequencer returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid) |-> in_ready)
    else $error("result issued while the sequencer was busy");

endmodule

bind polygon_centroid pcent_chk u_pcent_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid       (vert_i.valid),
  .in_ready       (vert_i.ready),
  .in_last        (vert_i.data.last_vertex),
  .res_valid      (res_o.valid),
  .res_ready      (res_o.ready),
  .res_degenerate (res_o.data.degenerate),
  .res_cx         (res_o.data.centroid_x),
  .res_cy         (res_o.data.centroid_y)
);
